### design/rlpp_pkg.sv
// rlpp_pkg: shared widths, constants and types for the radial lens point push.
// No dependencies; imported by every module of the block.
`default_nettype none

package rlpp_pkg;

    // Fixed-point format
    localparam int FRAC_BITS  = 8;
    localparam int ROOT_GUARD = 8;

    // Field widths
    localparam int POS_W      = 26;
    localparam int COL_W      = 7;
    localparam int DOT_W      = 16;
    localparam int RAD_W      = 24;
    localparam int CFG_IDX_W  = 2;

    // Datapath widths
    localparam int DIFF_W     = POS_W + 1;            // star minus centre
    localparam int SQ_W       = 2 * DIFF_W;           // squared offset, also sum width
    localparam int R2_W       = 2 * RAD_W;            // radius squared
    localparam int D2_W       = R2_W;                 // distance squared inside the lens
    localparam int MAG_W      = RAD_W;                // |offset| inside the lens
    localparam int RADC_W     = D2_W + 2 * ROOT_GUARD; // root radicand
    localparam int ROOT_W     = RADC_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int QUO_W      = RAD_W + 1;
    localparam int NUM_W      = R2_W + ROOT_GUARD + 1;
    localparam int OFS_W      = POS_W + 2;

    // Stars this close to the centre keep their position
    localparam logic [SQ_W-1:0] NEAR_LIMIT =
        SQ_W'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);

    localparam logic [DOT_W-1:0] DOT_RESET = DOT_W'(768);

    localparam logic signed [OFS_W-1:0] POS_MAX = OFS_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam logic signed [OFS_W-1:0] POS_MIN = OFS_W'(-(64'sd1 <<< (POS_W - 1)));

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 2'd0,
        CFG_CENTER_Y    = 2'd1,
        CFG_LENS_RADIUS = 2'd2,
        CFG_DOT_RADIUS  = 2'd3
    } cfg_idx_t;

    // Per-star data that rides along the pipeline
    typedef struct packed {
        logic signed [POS_W-1:0] star_x;
        logic signed [POS_W-1:0] star_y;
        logic [COL_W-1:0]        red;
        logic [COL_W-1:0]        green;
        logic [COL_W-1:0]        blue;
        logic [COL_W-1:0]        alpha;
        logic                    front;
        logic                    near;
        logic                    neg_x;
        logic                    neg_y;
        logic [MAG_W-1:0]        mag_x;
        logic [MAG_W-1:0]        mag_y;
    } side_t;

endpackage

`default_nettype wire

### design/rlpp_front.sv
// rlpp_front: offset from the lens centre, squared distance and inside test.
// Three stages; stars on or outside the circle are dropped here. Uses rlpp_pkg.
`default_nettype none

module rlpp_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [rlpp_pkg::POS_W-1:0]    center_x,
    input  logic signed [rlpp_pkg::POS_W-1:0]    center_y,
    input  logic [rlpp_pkg::RAD_W-1:0]           lens_radius,
    input  logic                                 in_vld,
    output logic                                 in_rdy,
    input  logic signed [rlpp_pkg::POS_W-1:0]    star_x,
    input  logic signed [rlpp_pkg::POS_W-1:0]    star_y,
    input  logic [rlpp_pkg::COL_W-1:0]           red,
    input  logic [rlpp_pkg::COL_W-1:0]           green,
    input  logic [rlpp_pkg::COL_W-1:0]           blue,
    input  logic [rlpp_pkg::COL_W-1:0]           alpha,
    input  logic                                 front,
    output logic                                 out_vld,
    input  logic                                 out_rdy,
    output rlpp_pkg::side_t                      out_side,
    output logic [rlpp_pkg::D2_W-1:0]            out_d2
);
    import rlpp_pkg::*;

    localparam int NS = 3;

    logic [NS-1:0]             vld_reg, vld_next;
    logic [NS:0]               adv;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic [R2_W-1:0]           rr_reg;
    logic [D2_W-1:0]           d2_reg;
    side_t                     s0_reg, s1_reg, s2_reg;
    side_t                     s0_next, s1_next, s2_next;
    logic [DIFF_W-1:0]         ax, ay;
    logic [SQ_W-1:0]           d2_sum;
    logic                      in_lens;

    // Stage advance: a stage loads when empty or when its successor moves
    always_comb
    begin
        adv[NS] = out_rdy;
        for (int i = NS - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i + 1];
        end
    end

    assign in_rdy = adv[0];

    // Stage 0 payload
    always_comb
    begin
        s0_next        = '0;
        s0_next.star_x = star_x;
        s0_next.star_y = star_y;
        s0_next.red    = red;
        s0_next.green  = green;
        s0_next.blue   = blue;
        s0_next.alpha  = alpha;
        s0_next.front  = front;
    end

    // Stage 1: magnitudes and signs
    always_comb
    begin
        ax = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
        ay = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
        s1_next       = s0_reg;
        s1_next.neg_x = dx_reg[DIFF_W-1];
        s1_next.neg_y = dy_reg[DIFF_W-1];
        s1_next.mag_x = ax[MAG_W-1:0];
        s1_next.mag_y = ay[MAG_W-1:0];
    end

    // Stage 2: distance squared against radius squared
    always_comb
    begin
        d2_sum       = sqx_reg + sqy_reg;
        in_lens      = d2_sum < SQ_W'(rr_reg);
        s2_next      = s1_reg;
        s2_next.near = d2_sum <= NEAR_LIMIT;
    end

    // Valid bits travel with the data
    always_comb
    begin
        vld_next[0] = adv[0] ? in_vld : vld_reg[0];
        vld_next[1] = adv[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = adv[2] ? (vld_reg[1] && in_lens) : vld_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg <= DIFF_W'(star_x) - DIFF_W'(center_x);
            dy_reg <= DIFF_W'(star_y) - DIFF_W'(center_y);
            s0_reg <= s0_next;
        end
        if (adv[1])
        begin
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            rr_reg  <= lens_radius * lens_radius;
            s1_reg  <= s1_next;
        end
        if (adv[2])
        begin
            d2_reg <= d2_sum[D2_W-1:0];
            s2_reg <= s2_next;
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign out_side = s2_reg;
    assign out_d2   = d2_reg;

endmodule

`default_nettype wire

### design/rlpp_sqrt.sv
// rlpp_sqrt: pipelined integer square root, one root bit per stage.
// Root of d2 scaled by the guard bits gives the distance with extra fraction. Uses rlpp_pkg.
`default_nettype none

module rlpp_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    output logic                          in_rdy,
    input  rlpp_pkg::side_t               in_side,
    input  logic [rlpp_pkg::D2_W-1:0]     in_d2,
    output logic                          out_vld,
    input  logic                          out_rdy,
    output rlpp_pkg::side_t               out_side,
    output logic [rlpp_pkg::ROOT_W-1:0]   out_root
);
    import rlpp_pkg::*;

    localparam int NS = ROOT_W;

    logic [NS-1:0]       vld_reg, vld_next;
    logic [NS:0]         adv;
    logic [RADC_W-1:0]   rad_reg [NS];
    logic [REM_W-1:0]    rem_reg [NS];
    logic [ROOT_W-1:0]   root_reg [NS];
    side_t               side_reg [NS];

    logic [RADC_W-1:0]   rad_in [NS];
    logic [REM_W-1:0]    rem_in [NS];
    logic [ROOT_W-1:0]   root_in [NS];
    logic [REM_W+1:0]    trial [NS];
    logic [REM_W+1:0]    test [NS];
    logic [RADC_W-1:0]   rad_nx [NS];
    logic [REM_W-1:0]    rem_nx [NS];
    logic [ROOT_W-1:0]   root_nx [NS];

    // Stage advance chain
    always_comb
    begin
        adv[NS] = out_rdy;
        for (int i = NS - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i + 1];
        end
    end

    assign in_rdy = adv[0];

    // One restoring root step per stage
    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (i == 0)
            begin
                rad_in[i]  = {in_d2, {(2 * ROOT_GUARD){1'b0}}};
                rem_in[i]  = '0;
                root_in[i] = '0;
            end
            else
            begin
                rad_in[i]  = rad_reg[i - 1];
                rem_in[i]  = rem_reg[i - 1];
                root_in[i] = root_reg[i - 1];
            end
            trial[i]  = {rem_in[i], rad_in[i][RADC_W-1 -: 2]};
            test[i]   = {2'b00, root_in[i], 2'b01};
            rad_nx[i] = {rad_in[i][RADC_W-3:0], 2'b00};
            if (trial[i] >= test[i])
            begin
                rem_nx[i]  = REM_W'(trial[i] - test[i]);
                root_nx[i] = {root_in[i][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_nx[i]  = trial[i][REM_W-1:0];
                root_nx[i] = {root_in[i][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Valid bits
    always_comb
    begin
        vld_next[0] = adv[0] ? in_vld : vld_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i - 1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (adv[i])
            begin
                rad_reg[i]  <= rad_nx[i];
                rem_reg[i]  <= rem_nx[i];
                root_reg[i] <= root_nx[i];
                side_reg[i] <= (i == 0) ? in_side : side_reg[i - 1];
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign out_side = side_reg[NS-1];
    assign out_root = root_reg[NS-1];

endmodule

`default_nettype wire

### design/rlpp_div.sv
// rlpp_div: offset magnitudes |d| * radius / distance, rounded half up.
// Multiply stage, numerator stage, then one quotient bit per stage. Uses rlpp_pkg.
`default_nettype none

module rlpp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rlpp_pkg::RAD_W-1:0]    lens_radius,
    input  logic                          in_vld,
    output logic                          in_rdy,
    input  rlpp_pkg::side_t               in_side,
    input  logic [rlpp_pkg::ROOT_W-1:0]   in_root,
    output logic                          out_vld,
    input  logic                          out_rdy,
    output rlpp_pkg::side_t               out_side,
    output logic [rlpp_pkg::QUO_W-1:0]    out_quo_x,
    output logic [rlpp_pkg::QUO_W-1:0]    out_quo_y
);
    import rlpp_pkg::*;

    localparam int NS = QUO_W + 2;

    logic [NS-1:0]       vld_reg, vld_next;
    logic [NS:0]         adv;
    side_t               side_reg [NS];
    logic [ROOT_W-1:0]   q_reg [NS];
    logic [NUM_W-1:0]    remx_reg [NS];
    logic [NUM_W-1:0]    remy_reg [NS];
    logic [QUO_W-1:0]    qx_reg [NS];
    logic [QUO_W-1:0]    qy_reg [NS];

    logic [R2_W-1:0]     prod_x, prod_y;
    logic [NUM_W-1:0]    dvs [NS];
    logic [NUM_W-1:0]    remx_nx [NS];
    logic [NUM_W-1:0]    remy_nx [NS];
    logic [QUO_W-1:0]    qx_nx [NS];
    logic [QUO_W-1:0]    qy_nx [NS];

    // Stage advance chain
    always_comb
    begin
        adv[NS] = out_rdy;
        for (int i = NS - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i + 1];
        end
    end

    assign in_rdy = adv[0];

    assign prod_x = in_side.mag_x * lens_radius;
    assign prod_y = in_side.mag_y * lens_radius;

    // Multiply, add rounding term, then restoring division bit by bit
    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            dvs[i] = '0;
            if (i == 0)
            begin
                remx_nx[i] = NUM_W'(prod_x);
                remy_nx[i] = NUM_W'(prod_y);
                qx_nx[i]   = '0;
                qy_nx[i]   = '0;
            end
            else if (i == 1)
            begin
                remx_nx[i] = NUM_W'({remx_reg[0][R2_W-1:0], {ROOT_GUARD{1'b0}}})
                           + NUM_W'(q_reg[0] >> 1);
                remy_nx[i] = NUM_W'({remy_reg[0][R2_W-1:0], {ROOT_GUARD{1'b0}}})
                           + NUM_W'(q_reg[0] >> 1);
                qx_nx[i]   = '0;
                qy_nx[i]   = '0;
            end
            else
            begin
                dvs[i]     = NUM_W'(q_reg[i - 1]) << (NS - 1 - i);
                remx_nx[i] = remx_reg[i - 1];
                remy_nx[i] = remy_reg[i - 1];
                qx_nx[i]   = qx_reg[i - 1];
                qy_nx[i]   = qy_reg[i - 1];
                if (remx_reg[i - 1] >= dvs[i])
                begin
                    remx_nx[i]           = remx_reg[i - 1] - dvs[i];
                    qx_nx[i][NS - 1 - i] = 1'b1;
                end
                if (remy_reg[i - 1] >= dvs[i])
                begin
                    remy_nx[i]           = remy_reg[i - 1] - dvs[i];
                    qy_nx[i][NS - 1 - i] = 1'b1;
                end
            end
        end
    end

    // Valid bits
    always_comb
    begin
        vld_next[0] = adv[0] ? in_vld : vld_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i - 1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (adv[i])
            begin
                side_reg[i] <= (i == 0) ? in_side : side_reg[i - 1];
                q_reg[i]    <= (i == 0) ? in_root : q_reg[i - 1];
                remx_reg[i] <= remx_nx[i];
                remy_reg[i] <= remy_nx[i];
                qx_reg[i]   <= qx_nx[i];
                qy_reg[i]   <= qy_nx[i];
            end
        end
    end

    assign out_vld   = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_quo_x = qx_reg[NS-1];
    assign out_quo_y = qy_reg[NS-1];

    // Division finished cleanly: remainder below divisor, push never past the rim
    a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld && !out_side.near) |-> (remx_reg[NS-1] < NUM_W'(q_reg[NS-1])))
        else $error("x remainder not below distance");
    a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld && !out_side.near) |-> (remy_reg[NS-1] < NUM_W'(q_reg[NS-1])))
        else $error("y remainder not below distance");
    a_quo_x: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld && !out_side.near) |-> (out_quo_x <= QUO_W'(lens_radius)))
        else $error("x offset beyond lens radius");
    a_quo_y: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld && !out_side.near) |-> (out_quo_y <= QUO_W'(lens_radius)))
        else $error("y offset beyond lens radius");

endmodule

`default_nettype wire

### design/radial_lens_point_push.sv
// Stages: 3 front, 32 root, 27 divide and 1 output stage between input transfer
// and output valid; stars on or outside the lens produce no transfer.
// Throughput: one star per cycle; every stage moves on its own, so bubbles close up
// and the input stalls only when all stages are full and the output is stalled.
// Reset clears all valid bits and loads the registers: centre 0, radius 0, dot size 768.
// Depends on rlpp_pkg, rlpp_front, rlpp_sqrt, rlpp_div.
`default_nettype none

module radial_lens_point_push (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rlpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rlpp_pkg::POS_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rlpp_pkg::POS_W-1:0]   star_x,
    input  logic signed [rlpp_pkg::POS_W-1:0]   star_y,
    input  logic [rlpp_pkg::COL_W-1:0]          in_red,
    input  logic [rlpp_pkg::COL_W-1:0]          in_green,
    input  logic [rlpp_pkg::COL_W-1:0]          in_blue,
    input  logic [rlpp_pkg::COL_W-1:0]          in_alpha,
    input  logic                                in_front,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rlpp_pkg::POS_W-1:0]   out_x,
    output logic signed [rlpp_pkg::POS_W-1:0]   out_y,
    output logic [rlpp_pkg::COL_W-1:0]          out_red,
    output logic [rlpp_pkg::COL_W-1:0]          out_green,
    output logic [rlpp_pkg::COL_W-1:0]          out_blue,
    output logic [rlpp_pkg::COL_W-1:0]          out_alpha,
    output logic [rlpp_pkg::DOT_W-1:0]          out_size,
    output logic                                out_front
);
    import rlpp_pkg::*;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [OFS_W-1:0] v);
        logic signed [OFS_W-1:0] c;
        c = v;
        if (c > POS_MAX)
        begin
            c = POS_MAX;
        end
        else if (c < POS_MIN)
        begin
            c = POS_MIN;
        end
        return c[POS_W-1:0];
    endfunction

    logic signed [POS_W-1:0]  center_x_reg, center_y_reg;
    logic [RAD_W-1:0]         lens_radius_reg;
    logic [DOT_W-1:0]         dot_radius_reg;

    logic                     fr_rdy, fr_vld, sq_rdy, sq_vld, dv_rdy, dv_vld;
    side_t                    fr_side, sq_side, dv_side;
    logic [D2_W-1:0]          fr_d2;
    logic [ROOT_W-1:0]        sq_root;
    logic [QUO_W-1:0]         quo_x, quo_y;

    logic signed [OFS_W-1:0]  off_x, off_y, sum_x, sum_y;
    logic signed [POS_W-1:0]  x_next, y_next;
    logic                     out_adv;

    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  x_reg, y_reg;
    logic [COL_W-1:0]         red_reg, green_reg, blue_reg, alpha_reg;
    logic [DOT_W-1:0]         size_reg;
    logic                     front_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            lens_radius_reg <= '0;
            dot_radius_reg  <= DOT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X:    center_x_reg    <= cfg_wdata;
                CFG_CENTER_Y:    center_y_reg    <= cfg_wdata;
                CFG_LENS_RADIUS: lens_radius_reg <= cfg_wdata[RAD_W-1:0];
                CFG_DOT_RADIUS:  dot_radius_reg  <= cfg_wdata[DOT_W-1:0];
                default:         ;
            endcase
        end
    end

    rlpp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .lens_radius (lens_radius_reg),
        .in_vld      (in_valid),
        .in_rdy      (fr_rdy),
        .star_x      (star_x),
        .star_y      (star_y),
        .red         (in_red),
        .green       (in_green),
        .blue        (in_blue),
        .alpha       (in_alpha),
        .front       (in_front),
        .out_vld     (fr_vld),
        .out_rdy     (sq_rdy),
        .out_side    (fr_side),
        .out_d2      (fr_d2)
    );

    rlpp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (fr_vld),
        .in_rdy   (sq_rdy),
        .in_side  (fr_side),
        .in_d2    (fr_d2),
        .out_vld  (sq_vld),
        .out_rdy  (dv_rdy),
        .out_side (sq_side),
        .out_root (sq_root)
    );

    rlpp_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .lens_radius (lens_radius_reg),
        .in_vld      (sq_vld),
        .in_rdy      (dv_rdy),
        .in_side     (sq_side),
        .in_root     (sq_root),
        .out_vld     (dv_vld),
        .out_rdy     (out_adv),
        .out_side    (dv_side),
        .out_quo_x   (quo_x),
        .out_quo_y   (quo_y)
    );

    assign in_stall = !fr_rdy;
    assign out_adv  = !out_valid_reg || !out_stall;

    // Signed offset from the centre, then clamp; near stars keep their own position
    always_comb
    begin
        off_x  = dv_side.neg_x ? -$signed({3'b000, quo_x}) : $signed({3'b000, quo_x});
        off_y  = dv_side.neg_y ? -$signed({3'b000, quo_y}) : $signed({3'b000, quo_y});
        sum_x  = OFS_W'(center_x_reg) + off_x;
        sum_y  = OFS_W'(center_y_reg) + off_y;
        x_next = dv_side.near ? dv_side.star_x : sat_pos(sum_x);
        y_next = dv_side.near ? dv_side.star_y : sat_pos(sum_y);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            red_reg   <= dv_side.red;
            green_reg <= dv_side.green;
            blue_reg  <= dv_side.blue;
            alpha_reg <= dv_side.alpha;
            size_reg  <= dot_radius_reg;
            front_reg <= dv_side.front;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;
    assign out_size  = size_reg;
    assign out_front = front_reg;

endmodule

`default_nettype wire

### sim/tb_radial_lens_point_push.sv
// Testbench for radial_lens_point_push: directed star table plus random stars,
// checked against an in-bench predictor of the radial push. Depends on rlpp_pkg and radial_lens_point_push.
`default_nettype none

module tb_radial_lens_point_push;
    import rlpp_pkg::*;

    localparam int RAND_STARS = 850;
    localparam int LATENCY    = 63;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [COL_W-1:0]        red;
        logic [COL_W-1:0]        green;
        logic [COL_W-1:0]        blue;
        logic [COL_W-1:0]        alpha;
        logic                    front;
    } star_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [COL_W-1:0]        red;
        logic [COL_W-1:0]        green;
        logic [COL_W-1:0]        blue;
        logic [COL_W-1:0]        alpha;
        logic [DOT_W-1:0]        size;
        logic                    front;
    } dot_t;

    // Directed row: star, whether a result is typed in, and that result
    typedef struct {
        star_t star;
        bit    typed;
        bit    hit;
        dot_t  dot;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [POS_W-1:0]        cfg_wdata;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [POS_W-1:0] star_x;
    logic signed [POS_W-1:0] star_y;
    logic [COL_W-1:0]        in_red;
    logic [COL_W-1:0]        in_green;
    logic [COL_W-1:0]        in_blue;
    logic [COL_W-1:0]        in_alpha;
    logic                    in_front;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic [COL_W-1:0]        out_red;
    logic [COL_W-1:0]        out_green;
    logic [COL_W-1:0]        out_blue;
    logic [COL_W-1:0]        out_alpha;
    logic [DOT_W-1:0]        out_size;
    logic                    out_front;

    radial_lens_point_push uut (.*);

    // Predictor copy of the lens registers
    logic signed [POS_W-1:0] lens_cx;
    logic signed [POS_W-1:0] lens_cy;
    logic [RAD_W-1:0]        lens_r;
    logic [DOT_W-1:0]        lens_dot;

    dot_t pending_dots[$];
    int   mismatches;
    int   dots_seen;
    int   stars_sent;
    int   long_hold;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #80000000;
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint push_along(longint d, longint unsigned q);
        longint unsigned mag;
        longint          off;
        mag = (d < 0) ? -d : d;
        off = longint'((((mag * lens_r) << ROOT_GUARD) + q / 2) / q);
        return (d < 0) ? -off : off;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(longint v);
        if (v > POS_MAX)
            v = POS_MAX;
        if (v < POS_MIN)
            v = POS_MIN;
        return v[POS_W-1:0];
    endfunction

    // Returns 1 and fills dot when the star lies strictly inside the lens
    function automatic bit push_star(star_t s, output dot_t dot);
        longint          dx;
        longint          dy;
        longint unsigned d2;
        longint unsigned q;
        longint          ox;
        longint          oy;
        dx  = longint'(s.x) - longint'(lens_cx);
        dy  = longint'(s.y) - longint'(lens_cy);
        d2  = dx * dx + dy * dy;
        dot = '0;
        if (d2 >= longint'(lens_r) * longint'(lens_r))
            return 0;
        if (d2 <= ((64'd1 << (2 * FRAC_BITS)) / 64'd1000000))
        begin
            ox = s.x;
            oy = s.y;
        end
        else
        begin
            q  = int_root(d2 << (2 * ROOT_GUARD));
            ox = longint'(lens_cx) + push_along(dx, q);
            oy = longint'(lens_cy) + push_along(dy, q);
        end
        dot.x     = clamp_pos(ox);
        dot.y     = clamp_pos(oy);
        dot.red   = s.red;
        dot.green = s.green;
        dot.blue  = s.blue;
        dot.alpha = s.alpha;
        dot.size  = lens_dot;
        dot.front = s.front;
        return 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [POS_W-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_CENTER_X:    lens_cx  = val;
            CFG_CENTER_Y:    lens_cy  = val;
            CFG_LENS_RADIUS: lens_r   = val[RAD_W-1:0];
            CFG_DOT_RADIUS:  lens_dot = val[DOT_W-1:0];
            default: ;
        endcase
    endtask

    // Wait for every expected dot, then for stragglers that cause none
    task automatic drain();
        while (pending_dots.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // Offer one star and hold it until the transfer
    task automatic send_star(star_t s, bit typed, bit hit, dot_t typed_dot);
        dot_t d;
        bit   in_lens;
        in_valid = 1'b1;
        {star_x, star_y, in_red, in_green, in_blue, in_alpha, in_front} = s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        in_lens = push_star(s, d);
        if (typed)
        begin
            if (in_lens != hit)
                report_mismatch("directed hit", in_lens, hit);
            if (hit)
                d = typed_dot;
        end
        if (in_lens)
            pending_dots.insert(pending_dots.size(), d);
        stars_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic star_t rand_star(int span);
        star_t s;
        s.x = POS_W'(lens_cx + $signed(POS_W'($urandom_range(2 * span, 0))) - span);
        s.y = POS_W'(lens_cy + $signed(POS_W'($urandom_range(2 * span, 0))) - span);
        if ($urandom_range(9, 0) == 0)
        begin
            s.x = POS_W'($urandom);
            s.y = POS_W'($urandom);
        end
        s.red   = COL_W'(($urandom_range(9, 0) == 0) ? $urandom_range(127, 0)
                                                     : $urandom_range(99, 0));
        s.green = COL_W'(($urandom_range(9, 0) == 0) ? $urandom_range(127, 0)
                                                     : $urandom_range(99, 0));
        s.blue  = COL_W'(($urandom_range(9, 0) == 0) ? $urandom_range(127, 0)
                                                     : $urandom_range(99, 0));
        s.alpha = COL_W'(($urandom_range(9, 0) == 0) ? $urandom_range(127, 0)
                                                     : $urandom_range(99, 0));
        s.front = 1'($urandom);
        return s;
    endfunction

    // Receiver stall pattern, with one long hold-off counted here
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                out_stall = 1'b1;
                long_hold--;
            end
            else
                case ((dots_seen / 64) % 3)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(3, 0) == 0);
                    default: out_stall = ($urandom_range(1, 0) == 0);
                endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            dot_t want;
            dots_seen++;
            if (pending_dots.size() == 0)
                report_mismatch("unexpected dot x", out_x, 0);
            else
            begin
                want = pending_dots.pop_front();
                if (out_x !== want.x)         report_mismatch("out_x", out_x, want.x);
                if (out_y !== want.y)         report_mismatch("out_y", out_y, want.y);
                if (out_red !== want.red)     report_mismatch("out_red", out_red, want.red);
                if (out_green !== want.green) report_mismatch("out_green", out_green, want.green);
                if (out_blue !== want.blue)   report_mismatch("out_blue", out_blue, want.blue);
                if (out_alpha !== want.alpha) report_mismatch("out_alpha", out_alpha, want.alpha);
                if (out_size !== want.size)   report_mismatch("out_size", out_size, want.size);
                if (out_front !== want.front) report_mismatch("out_front", out_front, want.front);
            end
        end
    end

    localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};

    row_t directed[$];

    task automatic add_row(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                           bit typed, bit hit, logic signed [POS_W-1:0] ex,
                           logic signed [POS_W-1:0] ey);
        row_t r;
        r.star  = '{x, y, 7'd99, 7'd0, 7'd127, 7'd50, x[0]};
        r.typed = typed;
        r.hit   = hit;
        r.dot   = '{ex, ey, 7'd99, 7'd0, 7'd127, 7'd50, lens_dot, x[0]};
        directed.insert(directed.size(), r);
    endtask

    initial
    begin
        star_t s;
        dot_t  none;
        int    burst;
        int    span;
        bit    held;
        none       = '0;
        mismatches = 0;
        dots_seen  = 0;
        stars_sent = 0;
        long_hold  = 0;
        held       = 1'b0;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_CENTER_X;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        {star_x, star_y, in_red, in_green, in_blue, in_alpha, in_front} = '0;
        lens_cx = 0; lens_cy = 0; lens_r = 0; lens_dot = DOT_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset the radius is zero: nothing comes out
        add_row(0, 0, 1, 0, 0, 0);
        add_row(PMAX, PMIN, 1, 0, 0, 0);
        foreach (directed[i])
            send_star(directed[i].star, directed[i].typed, directed[i].hit, directed[i].dot);
        drain();
        directed.delete();

        // Radius 1.0 at the origin: centre stays, axis stars land on the rim
        write_reg(CFG_LENS_RADIUS, 256);
        add_row(0, 0, 1, 1, 0, 0);
        add_row(100, 0, 1, 1, 256, 0);
        add_row(0, -100, 1, 1, 0, -256);
        add_row(256, 0, 1, 0, 0, 0);
        add_row(255, 0, 1, 1, 256, 0);
        add_row(60, 70, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 0);
        foreach (directed[i])
            send_star(directed[i].star, directed[i].typed, directed[i].hit, directed[i].dot);
        drain();
        directed.delete();

        // Extreme radius just off the corner: centre star stays, corner star saturates
        write_reg(CFG_CENTER_X, POS_W'(PMAX - 100));
        write_reg(CFG_CENTER_Y, POS_W'(PMIN + 100));
        write_reg(CFG_LENS_RADIUS, POS_W'(24'hFFFFFF));
        write_reg(CFG_DOT_RADIUS, POS_W'(16'hFFFF));
        add_row(POS_W'(PMAX - 100), POS_W'(PMIN + 100), 1, 1,
                POS_W'(PMAX - 100), POS_W'(PMIN + 100));
        add_row(PMAX, PMIN, 1, 1, PMAX, PMIN);
        add_row(POS_W'(PMAX - 1000), PMIN, 0, 0, 0, 0);
        add_row(PMIN, PMAX, 1, 0, 0, 0);
        foreach (directed[i])
            send_star(directed[i].star, directed[i].typed, directed[i].hit, directed[i].dot);
        drain();

        // Random phases with different lens settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_CENTER_X, (ph == 5) ? PMIN : POS_W'($urandom));
            write_reg(CFG_CENTER_Y, (ph == 5) ? PMAX : POS_W'($urandom));
            write_reg(CFG_LENS_RADIUS, POS_W'((ph == 0) ? 24'd0 :
                      (ph == 1) ? 24'hFFFFFF : $urandom_range(24'hFFFFFF, 1)));
            write_reg(CFG_DOT_RADIUS, POS_W'((ph == 2) ? 16'd0 : 16'($urandom)));
            span = (lens_r == 0) ? 1000 : int'(lens_r) + int'(lens_r) / 4 + 2;
            if (span > 33554431 || span < 0)
                span = 33554431;
            for (int n = 0; n < RAND_STARS / 6; )
            begin
                burst = $urandom_range(30, 1);
                if (ph == 3 && !held && n >= 20)
                begin
                    long_hold = 300;
                    held      = 1'b1;
                end
                for (int b = 0; b < burst && n < RAND_STARS / 6; b++, n++)
                begin
                    s = rand_star(span);
                    send_star(s, 0, 0, none);
                end
                if (ph != 3)
                    repeat ($urandom_range(6, 0)) @(negedge clk);
            end
            // Sender waits until everything expected has arrived
            drain();
        end

        repeat (LATENCY + 8) @(negedge clk);
        $display("Sent %0d stars over several lens settings; %0d dots checked", stars_sent,
                 dots_seen);
        if (mismatches == 0 && pending_dots.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
